// ===== hdl/plsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list store package
// Shared constants, codes and control types of the positional list store.
// ----------------------------------------------------------------------------
package plsu_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned ELEM_WIDTH = 32;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNTO_W  = 7;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic rd_shift;
    logic wr_shift;
    logic wr_val;
    logic rd_pos;
    logic finish;
  } plsu_cmd_t;

  typedef struct packed {
    logic              ok;
    logic [MODE_W-1:0] mode;
    logic              shift_done;
    logic              out_busy;
  } plsu_status_t;

endpackage

// ===== hdl/plsu_if.sv =====
// ----------------------------------------------------------------------------
// Positional list store channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface plsu_in_if;
  import plsu_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  element_value;

  modport source (output valid, mode, position, element_value, input ready);
  modport sink   (input valid, mode, position, element_value, output ready);
endinterface

interface plsu_out_if;
  import plsu_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [VAL_W-1:0]  read_value;
  logic [CNTO_W-1:0] item_count;

  modport source (output valid, ok, read_value, item_count, input ready);
  modport sink   (input valid, ok, read_value, item_count, output ready);
endinterface

// ===== hdl/positional_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// Positional list store unit
// Ordered list with insert, delete and read at a one-based position.
// ----------------------------------------------------------------------------
// Requests enter on in_i (mode, position, element_value) and each one gives
// exactly one transaction on out_o (ok, read_value, item_count), in order.
// One request is worked on at a time; in_i.ready is high only while the
// block waits for a new request.
// The elements sit in a single-port-per-direction RAM, so an insert or a
// delete moves one element at a time in three steps (read, write, check).
// With n elements moved (insert: count-position+1, delete: count-position,
// read or rejected request: none) the result is registered once the n
// moves are done, and only then is the next request taken.
// The result waits in an output register; a new request may be taken while
// it waits, but its own result is held back until the previous transaction
// on out_o has completed.
// Reset empties the list at once; the RAM contents are not cleared because
// cells above the count are never read.
// ----------------------------------------------------------------------------
module positional_list_store_unit import plsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  plsu_in_if.sink    in_i,
  plsu_out_if.source out_o
);

  plsu_cmd_t    cmd;
  plsu_status_t status;

  plsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  plsu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .mode_i          (in_i.mode),
    .position_i      (in_i.position),
    .element_value_i (in_i.element_value),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .ok_o            (out_o.ok),
    .read_value_o    (out_o.read_value),
    .item_count_o    (out_o.item_count)
  );

endmodule

// ===== hdl/plsu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module plsu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/plsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional list store controller
// Sequences capture, element shifting, access and result delivery.
// ----------------------------------------------------------------------------
module plsu_ctrl import plsu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  plsu_status_t status_i,
  output plsu_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status_i.ok) begin
          state_d = ST_FINISH;
        end else if (status_i.mode == MODE_READ) begin
          state_d = ST_FINISH;
        end else if (status_i.shift_done) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = ST_EXEC;
      ST_FINISH: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        if (status_i.ok) begin
          if (status_i.mode == MODE_READ) begin
            cmd_o.rd_pos = 1'b1;
          end else if (status_i.shift_done && status_i.mode == MODE_INSERT) begin
            cmd_o.wr_val = 1'b1;
          end
        end
      end
      ST_SHIFT_RD: cmd_o.rd_shift = 1'b1;
      ST_SHIFT_WR: cmd_o.wr_shift = 1'b1;
      ST_FINISH:   cmd_o.finish   = !status_i.out_busy;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/plsu_dp.sv =====
// ----------------------------------------------------------------------------
// Positional list store datapath
// Element memory, fill count, shift cursor and the result register.
// ----------------------------------------------------------------------------
module plsu_dp import plsu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plsu_cmd_t         cmd_i,
  output plsu_status_t      status_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [VAL_W-1:0]  element_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [VAL_W-1:0]  read_value_o,
  output logic [CNTO_W-1:0] item_count_o
);

  logic [MODE_W-1:0]     mode_q;
  logic [POS_W-1:0]      pos_q;
  logic [ELEM_WIDTH-1:0] val_q;
  logic                  ok_q, ok_d;
  logic [CNT_W-1:0]      cur_q, cur_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic                  out_ok_q;
  logic [VAL_W-1:0]      out_read_q;
  logic [CNTO_W-1:0]     out_count_q;

  logic [CMP_W-1:0]      in_pos_c, in_cnt_c, pos_c, cur_c, cnt_c;
  logic                  shift_done;
  logic                  we, re;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [ELEM_WIDTH-1:0] wdata, rdata;
  logic [IDX_W-1:0]      pos_idx;

  assign in_pos_c = CMP_W'(position_i);
  assign in_cnt_c = CMP_W'(count_q);
  assign pos_c    = CMP_W'(pos_q);
  assign cur_c    = CMP_W'(cur_q);
  assign cnt_c    = CMP_W'(count_q);
  assign pos_idx  = IDX_W'(pos_q - POS_W'(1));

  always_comb begin
    ok_d  = 1'b0;
    cur_d = count_q;
    case (mode_i)
      MODE_INSERT: begin
        ok_d  = (position_i != '0) && (in_cnt_c < CMP_W'(DEPTH)) &&
                (in_pos_c <= in_cnt_c + CMP_W'(1));
        cur_d = count_q;
      end
      MODE_DELETE, MODE_READ: begin
        ok_d  = (position_i != '0) && (in_pos_c <= in_cnt_c);
        cur_d = CNT_W'(position_i);
      end
      default: ok_d = 1'b0;
    endcase
  end

  assign shift_done = (mode_q == MODE_INSERT) ? (cur_c + CMP_W'(1) == pos_c)
                                              : (cur_c >= cnt_c);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = pos_idx;
    raddr = pos_idx;
    wdata = val_q;
    if (cmd_i.rd_shift) begin
      re    = 1'b1;
      raddr = (mode_q == MODE_INSERT) ? IDX_W'(cur_q - CNT_W'(1)) : IDX_W'(cur_q);
    end else if (cmd_i.rd_pos) begin
      re = 1'b1;
    end
    if (cmd_i.wr_shift) begin
      we    = 1'b1;
      wdata = rdata;
      waddr = (mode_q == MODE_INSERT) ? IDX_W'(cur_q) : IDX_W'(cur_q - CNT_W'(1));
    end else if (cmd_i.wr_val) begin
      we = 1'b1;
    end
  end

  plsu_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      val_q  <= ELEM_WIDTH'(element_value_i);
      ok_q   <= ok_d;
      cur_q  <= cur_d;
    end else if (cmd_i.wr_shift) begin
      cur_q <= (mode_q == MODE_INSERT) ? cur_q - CNT_W'(1) : cur_q + CNT_W'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (ok_q && mode_q == MODE_INSERT) begin
      count_d = count_q + CNT_W'(1);
    end else if (ok_q && mode_q == MODE_DELETE) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_ok_q    <= ok_q;
      out_read_q  <= (ok_q && mode_q == MODE_READ) ? VAL_W'(rdata) : '0;
      out_count_q <= CNTO_W'(count_d);
    end
  end

  assign status_o.ok         = ok_q;
  assign status_o.mode       = mode_q;
  assign status_o.shift_done = shift_done;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign read_value_o = out_read_q;
  assign item_count_o = out_count_q;

endmodule

// ===== hdl/plsu_checker.sv =====
// ----------------------------------------------------------------------------
// Positional list store checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module plsu_checker import plsu_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              ok_i,
  input logic [VAL_W-1:0]  read_value_i,
  input logic [CNTO_W-1:0] item_count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(item_count_i))
    else $error("Result dropped or changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("New request taken while one is in progress.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> item_count_i <= CNTO_W'(DEPTH))
    else $error("Element count exceeds the list depth.");

  a_read_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> read_value_i == '0)
    else $error("Rejected request returned nonzero data.");

endmodule

bind positional_list_store_unit plsu_checker u_plsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .ok_i         (out_o.ok),
  .read_value_i (out_o.read_value),
  .item_count_i (out_o.item_count)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list store unit testbench
// Drives insert, delete and read requests into the list store and predicts
// every response from a local copy of the list. Directed tests cover the
// empty list, the edits at both ends, the full list and an output stall.
// Random traffic then follows, first with idle bursts on both sides and
// finally as a steady stream.
// ----------------------------------------------------------------------------
module tb_top;
  import plsu_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 250;
  localparam int unsigned HOLD_CYCLES = 400;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  read_value;
    logic [CNTO_W-1:0] item_count;
  } list_result_t;

  logic clk;
  logic rst_ni;

  plsu_in_if  in_ch ();
  plsu_out_if out_ch ();

  positional_list_store_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic [ELEM_WIDTH-1:0] list_model [DEPTH];
  int                    list_len;
  list_result_t          expected_results [$];
  list_result_t          oldest_result;
  int unsigned           fail_count;
  int unsigned           stall_cycles;
  int unsigned           hold_left;
  int unsigned           sink_burst;
  bit                    src_idle_en;
  bit                    sink_idle_en;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic list_result_t apply_request(logic [MODE_W-1:0] mode,
                                                 logic [POS_W-1:0]  position,
                                                 logic [VAL_W-1:0]  value);
    list_result_t res;
    int           pos;
    res = '0;
    pos = int'(position);
    case (mode)
      MODE_INSERT: begin
        if (pos >= 1 && list_len < DEPTH && pos <= list_len + 1) begin
          for (int k = list_len; k >= pos; k--) list_model[k] = list_model[k-1];
          list_model[pos-1] = value[ELEM_WIDTH-1:0];
          list_len++;
          res.ok = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (pos >= 1 && pos <= list_len) begin
          for (int k = pos; k < list_len; k++) list_model[k-1] = list_model[k];
          list_len--;
          res.ok = 1'b1;
        end
      end
      MODE_READ: begin
        if (pos >= 1 && pos <= list_len) begin
          res.read_value = VAL_W'(list_model[pos-1]);
          res.ok         = 1'b1;
        end
      end
      default: ;
    endcase
    res.item_count = CNTO_W'(list_len);
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] random_element();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                              logic [VAL_W-1:0] value);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.position      <= position;
    in_ch.element_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(apply_request(mode, position, value));
  endtask

  task automatic send_random_item(bit growing);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      send_request(MODE_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 127)),
                   random_element());
    end else if (sel < 30) begin
      send_request(MODE_READ, POS_W'(list_len == 0 ? 1 : $urandom_range(1, list_len)),
                   random_element());
    end else if ($urandom_range(0, 99) < (growing ? 75 : 25)) begin
      send_request(MODE_INSERT, POS_W'($urandom_range(1, list_len + 1)), random_element());
    end else begin
      send_request(MODE_DELETE, POS_W'(list_len == 0 ? 1 : $urandom_range(1, list_len)),
                   random_element());
    end
  endtask

  task automatic test_empty_list();
    send_request(MODE_READ, 7'd0, random_element());
    send_request(MODE_READ, 7'd1, random_element());
    send_request(MODE_DELETE, 7'd0, random_element());
    send_request(MODE_DELETE, 7'd1, random_element());
    send_request(MODE_INSERT, 7'd0, 32'h1234_5678);
    send_request(MODE_INSERT, 7'd2, 32'h8765_4321);
    send_request(MODE_SPARE, 7'd1, '1);
  endtask

  task automatic test_directed_edits();
    send_request(MODE_INSERT, 7'd1, 32'h0000_0000);
    send_request(MODE_INSERT, 7'd2, 32'hFFFF_FFFF);
    send_request(MODE_INSERT, 7'd1, 32'hA5A5_5A5A);
    send_request(MODE_INSERT, 7'd5, 32'hDEAD_BEEF);
    send_request(MODE_READ, 7'd1, '0);
    send_request(MODE_READ, 7'd2, '0);
    send_request(MODE_READ, 7'd3, '0);
    send_request(MODE_READ, 7'd4, '0);
    send_request(MODE_READ, 7'd127, '1);
    send_request(MODE_SPARE, 7'd1, '1);
    send_request(MODE_DELETE, 7'd4, '0);
    send_request(MODE_DELETE, 7'd2, '0);
    send_request(MODE_DELETE, 7'd1, '0);
    send_request(MODE_READ, 7'd1, '0);
  endtask

  task automatic test_full_list();
    while (list_len < DEPTH)
      send_request(MODE_INSERT, POS_W'($urandom_range(1, list_len + 1)), random_element());
    send_request(MODE_INSERT, POS_W'(DEPTH + 1), random_element());
    send_request(MODE_INSERT, 7'd1, random_element());
    send_request(MODE_READ, POS_W'(DEPTH), '0);
    send_request(MODE_READ, POS_W'(DEPTH + 1), '0);
    send_request(MODE_DELETE, POS_W'(DEPTH + 1), '0);
    send_request(MODE_DELETE, POS_W'(DEPTH), '0);
    send_request(MODE_INSERT, POS_W'(DEPTH), 32'hFFFF_FFFF);
    send_request(MODE_READ, POS_W'(DEPTH), '0);
  endtask

  task automatic test_output_stall();
    src_idle_en = 1'b0;
    hold_left   = HOLD_CYCLES;
    send_request(MODE_READ, 7'd1, '0);
    send_request(MODE_DELETE, 7'd1, '0);
    send_request(MODE_READ, POS_W'(DEPTH - 1), '0);
    send_request(MODE_INSERT, 7'd1, random_element());
    send_request(MODE_READ, 7'd1, '0);
    send_request(MODE_DELETE, POS_W'(DEPTH), '0);
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    bit growing;
    growing = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (list_len == DEPTH) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      else if ($urandom_range(0, 59) == 0) growing = !growing;
      send_random_item(growing);
    end
  endtask

  task automatic test_steady_stream(int unsigned n_items);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) send_random_item(bit'($urandom_range(0, 1)));
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    sink_burst = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (sink_burst > 0) begin
        out_ch.ready <= 1'b0;
        sink_burst--;
      end else if (sink_idle_en && rst_ni && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        sink_burst = $urandom_range(0, 12);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("Response transaction with no request outstanding.");
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_ch.ok !== oldest_result.ok) begin
          $error("ok: expected %0d, actual %0d", oldest_result.ok, out_ch.ok);
          fail_count++;
        end
        if (out_ch.read_value !== oldest_result.read_value) begin
          $error("read_value: expected %h, actual %h", oldest_result.read_value,
                 out_ch.read_value);
          fail_count++;
        end
        if (out_ch.item_count !== oldest_result.item_count) begin
          $error("item_count: expected %0d, actual %0d", oldest_result.item_count,
                 out_ch.item_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("positional_list_store_unit regression: fail");
    $finish;
  end

  initial begin
    fail_count   = 0;
    stall_cycles = 0;
    hold_left    = 0;
    list_len     = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    foreach (list_model[k]) list_model[k] = '0;
    rst_ni              <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= '0;
    in_ch.position      <= '0;
    in_ch.element_value <= '0;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_directed_edits();
    test_full_list();
    test_output_stall();
    test_random_traffic(690);
    test_steady_stream(60);

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("positional_list_store_unit regression: pass");
    end else begin
      $display("positional_list_store_unit regression: fail");
    end
    $finish;
  end

endmodule
